@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// implication checks on the rising edge of a named clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SPU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPU_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/spu_pkg.sv @@
// ----------------------------------------------------------------------------
// spu_pkg
// shared types and constants of the starfield projection update unit
// ----------------------------------------------------------------------------
`default_nettype none
package spu_pkg;

    localparam int MAX_STARS_DEF = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_W       = 40;
    localparam int OUT_W      = 32;

    localparam int POS_W  = 19;
    localparam int Z_W    = 17;
    localparam int PIX_W  = 13;
    localparam int TINT_W = 2;
    localparam int NUM_W  = 28;
    localparam int DEN_W  = 16;
    localparam int Q_W    = NUM_W + 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STAR_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_LEFT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_RIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_BOTTOM = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_TOP    = 3'd5;

    // tint codes
    localparam logic [TINT_W-1:0] TINT_WHITE = 2'd0;
    localparam logic [TINT_W-1:0] TINT_CYAN  = 2'd1;
    localparam logic [TINT_W-1:0] TINT_RED   = 2'd2;

    localparam logic [15:0] CREDIT_STEP = 16'd3;
    localparam logic [15:0] CREDIT_MAX  = 16'hFFFF;
    localparam int          EYE_SHIFT   = 9;
    localparam logic signed [29:0] FAR_DEPTH = 30'sd45000;
    localparam logic signed [Z_W-1:0] SPAWN_DEPTH = 17'sd45512;
    localparam logic signed [Z_W-1:0] Z_EMPTY     = -17'sd1;
    localparam logic signed [PIX_W-1:0] PIX_NONE  = -13'sd1;

    typedef struct packed {
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [Z_W-1:0]    z;
        logic        [TINT_W-1:0] tint;
        logic signed [PIX_W-1:0]  opx;
        logic signed [PIX_W-1:0]  opy;
    } t_star;

    localparam int STAR_W = $bits(t_star);

endpackage
`default_nettype wire

@@ rtl/starfield_projection_update_unit.sv @@
// ----------------------------------------------------------------------------
// starfield_projection_update_unit
// visits one star slot per item: erase, move, project, draw, respawn
// ----------------------------------------------------------------------------
// latency from one accept to the next follows the path: a dead slot is read,
//   decided and written, a star out of depth adds an erase, a projected star both
//   divisions, the check and, on screen, a draw, a respawn the spawn steps.
//   Items go one at a time, a projected star held by the single bit-serial
//   divider shared by both coordinates. Reset is synchronous, then a clearing
//   pass empties the star ram before the first item is accepted
`default_nettype none
`include "assert_macros.svh"
module starfield_projection_update_unit #(
    parameter int MAX_STARS = spu_pkg::MAX_STARS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // config write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [spu_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [spu_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // rand_x[14:0], rand_y[29:15], tint_gate[35:30], tint_pick[36], zero pad
    input  wire logic [spu_pkg::IN_W-1:0]      s_axis_tdata,
    // result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // pixel_x[12:0], pixel_y[25:13], tint[27:26], zero pad
    output logic      [spu_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tlast,   // last_of_item
    // is_draw[0]
    output logic                               m_axis_tuser
);
    import spu_pkg::*;

    localparam int PTR_W = $clog2(MAX_STARS);
    localparam int CW    = (PTR_W + 1 > 13) ? PTR_W + 1 : 13;

    typedef enum logic [13:0] {
        S_CLEAR  = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_READ   = 14'b00000000000100,
        S_DIVX   = 14'b00000000001000,
        S_DIVY   = 14'b00000000010000,
        S_CHECK  = 14'b00000000100000,
        S_EMIT_E = 14'b00000001000000,
        S_EMIT_D = 14'b00000010000000,
        S_DECIDE = 14'b00000100000000,
        S_SPAWN1 = 14'b00001000000000,
        S_SPAWN2 = 14'b00010000000000,
        S_SPAWN3 = 14'b00100000000000,
        S_WRITE  = 14'b01000000000000,
        S_SPARE  = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // config registers
    logic [11:0] r_speed, r_left, r_right, r_bottom, r_top;
    logic [12:0] r_star_count;

    // control
    logic [PTR_W-1:0] r_clr, r_ptr, r_slot;
    logic [15:0]      r_credit;

    // per-item working set
    logic [14:0] r_rx, r_ry;
    logic [5:0]  r_gate;
    logic        r_pick;
    logic signed [POS_W-1:0] r_px, r_py;
    logic signed [Z_W-1:0]   r_z;
    logic [TINT_W-1:0]       r_tint;
    logic signed [PIX_W-1:0] r_opx, r_opy, r_npx, r_npy;
    logic                    r_draw;
    logic signed [Q_W-1:0]   r_qx;
    logic                    r_neg;
    logic [NUM_W-1:0]        r_num;
    logic                    r_go;
    logic signed [29:0]      r_mx, r_my;
    logic signed [POS_W-1:0] r_xs, r_ys;

    // output register
    logic                    r_mv, r_mdraw, r_mlast;
    logic signed [PIX_W-1:0] r_mpx, r_mpy;
    logic [TINT_W-1:0]       r_mtint;

    logic             w_accept, w_out_free;
    logic [CW-1:0]    w_cnt, w_s, w_s1;
    logic [PTR_W-1:0] w_snext;
    logic             w_we;
    logic [PTR_W-1:0] w_waddr;
    t_star            w_wdata, w_rd;
    logic [STAR_W-1:0] w_rdata;
    logic             w_div_done;
    logic [NUM_W-1:0] w_quot;
    logic signed [Q_W-1:0]   w_q;
    logic signed [Z_W:0]     w_znew_wide;
    logic signed [Z_W-1:0]   w_znew;
    logic                    w_live;
    logic [11:0]             w_xc, w_yc;
    logic signed [29:0]      w_x, w_y;
    logic                    w_onscreen;
    logic signed [12:0]      w_hx, w_hy;
    logic signed [29:0]      w_tx, w_ty;
    logic signed [34:0]      w_prx, w_pry;
    logic [TINT_W-1:0]       w_new_tint;

    // ---------------- slot selection ----------------
    always_comb begin
        w_cnt = CW'(r_star_count);
        if (w_cnt == '0) begin
            w_cnt = CW'(1);
        end
        if (w_cnt > CW'(MAX_STARS)) begin
            w_cnt = CW'(MAX_STARS);
        end
        // pointer past a lowered count restarts the pass
        w_s  = (CW'(r_ptr) >= w_cnt) ? '0 : CW'(r_ptr);
        w_s1 = w_s + CW'(1);
        w_snext = (w_s1 >= w_cnt) ? '0 : w_s1[PTR_W-1:0];
    end

    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign w_out_free    = !r_mv || m_axis_tready;

    // ---------------- star ram ----------------
    assign w_we    = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign w_waddr = (r_state == S_CLEAR) ? r_clr : r_slot;

    always_comb begin
        if (r_state == S_CLEAR) begin
            w_wdata.px   = '0;
            w_wdata.py   = '0;
            w_wdata.z    = Z_EMPTY;
            w_wdata.tint = TINT_WHITE;
            w_wdata.opx  = PIX_NONE;
            w_wdata.opy  = PIX_NONE;
        end else begin
            w_wdata.px   = r_px;
            w_wdata.py   = r_py;
            w_wdata.z    = r_z;
            w_wdata.tint = r_tint;
            // a drawn star remembers its new point
            w_wdata.opx  = r_draw ? r_npx : r_opx;
            w_wdata.opy  = r_draw ? r_npy : r_opy;
        end
    end

    spu_ram #(
        .WIDTH (STAR_W),
        .DEPTH (MAX_STARS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept),
        .i_raddr (w_s[PTR_W-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_rd = t_star'(w_rdata);

    // ---------------- shared divider ----------------
    spu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_num   (r_num),
        .i_den   (r_z[DEN_W-1:0]),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // quotient truncates toward zero: negate the magnitude for negative coords
    assign w_q = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});

    // ---------------- datapath helpers ----------------
    assign w_znew_wide = $signed({w_rd.z[Z_W-1], w_rd.z}) - $signed({6'd0, r_speed});
    assign w_znew      = w_znew_wide[Z_W-1:0];
    assign w_live      = w_rd.z > 0;

    // screen centers
    assign w_xc = 12'(({1'b0, r_left} + {1'b0, r_right}) >> 1);
    assign w_yc = 12'(({1'b0, r_bottom} + {1'b0, r_top}) >> 1);

    assign w_x = 30'(r_qx) + $signed({18'd0, w_xc});
    assign w_y = 30'(w_q)  + $signed({18'd0, w_yc});
    assign w_onscreen = !(w_x > $signed({18'd0, r_right})  || w_x < $signed({18'd0, r_left}) ||
                          w_y > $signed({18'd0, r_top})    || w_y < $signed({18'd0, r_bottom}));

    // spawn range: half span plus one, scaled by the far depth over 512
    assign w_hx = ($signed({1'b0, r_right}) - $signed({1'b0, r_left})) >>> 1;
    assign w_hy = ($signed({1'b0, r_top}) - $signed({1'b0, r_bottom})) >>> 1;
    // truncate toward zero on the shift by 512
    assign w_tx = (r_mx + (r_mx < 0 ? 30'sd511 : 30'sd0)) >>> EYE_SHIFT;
    assign w_ty = (r_my + (r_my < 0 ? 30'sd511 : 30'sd0)) >>> EYE_SHIFT;
    // 2xs * 2r / 65536 is xs * r / 16384, floored by the arithmetic shift
    assign w_prx = 35'(r_xs) * $signed({20'd0, r_rx});
    assign w_pry = 35'(r_ys) * $signed({20'd0, r_ry});

    assign w_new_tint = (r_gate != '0) ? TINT_WHITE : (r_pick ? TINT_CYAN : TINT_RED);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == PTR_W'(MAX_STARS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (w_live && w_znew > 0) begin
                    n_state = S_DIVX;
                end else if (w_live) begin
                    n_state = S_EMIT_E;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_DIVX: begin
                if (w_div_done) begin
                    n_state = S_DIVY;
                end
            end
            S_DIVY: begin
                if (w_div_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: n_state = S_EMIT_E;
            S_EMIT_E: begin
                if (w_out_free) begin
                    n_state = r_draw ? S_EMIT_D : S_DECIDE;
                end
            end
            S_EMIT_D: begin
                if (w_out_free) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = (r_credit != '0 && r_z <= 0) ? S_SPAWN1 : S_WRITE;
            end
            S_SPAWN1: n_state = S_SPAWN2;
            S_SPAWN2: n_state = S_SPAWN3;
            S_SPAWN3: n_state = S_WRITE;
            S_WRITE:  n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_ptr        <= '0;
            r_credit     <= '0;
            r_go         <= 1'b0;
            r_mv         <= 1'b0;
            r_speed      <= 12'd64;
            r_star_count <= 13'd1054;
            r_left       <= 12'd0;
            r_right      <= 12'd639;
            r_bottom     <= 12'd0;
            r_top        <= 12'd479;
        end else begin
            r_state <= n_state;
            r_go    <= 1'b0;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SPEED:         r_speed      <= i_cfg_data[11:0];
                    CFG_STAR_COUNT:    r_star_count <= i_cfg_data;
                    CFG_SCREEN_LEFT:   r_left       <= i_cfg_data[11:0];
                    CFG_SCREEN_RIGHT:  r_right      <= i_cfg_data[11:0];
                    CFG_SCREEN_BOTTOM: r_bottom     <= i_cfg_data[11:0];
                    CFG_SCREEN_TOP:    r_top        <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_ptr <= w_snext;
                // a visit to slot zero opens a pass and earns spawn credit
                if (w_s == '0) begin
                    r_credit <= (r_credit > CREDIT_MAX - CREDIT_STEP) ? CREDIT_MAX
                                                                     : r_credit + CREDIT_STEP;
                end
            end
            if (r_state == S_SPAWN3) begin
                r_credit <= r_credit - 1'b1;
            end
            if ((r_state == S_READ && w_live && w_znew > 0) ||
                (r_state == S_DIVX && w_div_done)) begin
                r_go <= 1'b1;
            end
            // output register: cleared when taken, reloaded by the emit states
            if (m_axis_tready) begin
                r_mv <= 1'b0;
            end
            if ((r_state == S_EMIT_E || r_state == S_EMIT_D) && w_out_free) begin
                r_mv <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_slot <= w_s[PTR_W-1:0];
                    r_rx   <= s_axis_tdata[14:0];
                    r_ry   <= s_axis_tdata[29:15];
                    r_gate <= s_axis_tdata[35:30];
                    r_pick <= s_axis_tdata[36];
                end
            end
            S_READ: begin
                r_px   <= w_rd.px;
                r_py   <= w_rd.py;
                r_tint <= w_rd.tint;
                r_opx  <= w_rd.opx;
                r_opy  <= w_rd.opy;
                r_z    <= w_live ? w_znew : w_rd.z;
                r_draw <= 1'b0;
                r_neg  <= w_rd.px < 0;
                r_num  <= {POS_W'(w_rd.px < 0 ? -w_rd.px : w_rd.px), EYE_SHIFT'(0)};
            end
            S_DIVX: begin
                if (w_div_done) begin
                    r_qx  <= w_q;
                    r_neg <= r_py < 0;
                    r_num <= {POS_W'(r_py < 0 ? -r_py : r_py), EYE_SHIFT'(0)};
                end
            end
            S_DIVY: begin
                if (w_div_done) begin
                    r_neg <= 1'b0;
                    if (w_onscreen) begin
                        r_draw <= 1'b1;
                        r_npx  <= w_x[PIX_W-1:0];
                        r_npy  <= w_y[PIX_W-1:0];
                    end else begin
                        r_z <= Z_EMPTY;
                    end
                end
            end
            S_EMIT_E: begin
                if (w_out_free) begin
                    r_mpx   <= r_opx;
                    r_mpy   <= r_opy;
                    r_mtint <= r_tint;
                    r_mdraw <= 1'b0;
                    r_mlast <= !r_draw;
                end
            end
            S_EMIT_D: begin
                if (w_out_free) begin
                    r_mpx   <= r_npx;
                    r_mpy   <= r_npy;
                    r_mtint <= r_tint;
                    r_mdraw <= 1'b1;
                    r_mlast <= 1'b1;
                end
            end
            S_SPAWN1: begin
                r_mx <= 30'(w_hx + 13'sd1) * FAR_DEPTH;
                r_my <= 30'(w_hy + 13'sd1) * FAR_DEPTH;
            end
            S_SPAWN2: begin
                r_xs <= POS_W'(w_tx);
                r_ys <= POS_W'(w_ty);
            end
            S_SPAWN3: begin
                r_px   <= POS_W'((w_prx >>> 14) - 35'(r_xs));
                r_py   <= POS_W'((w_pry >>> 14) - 35'(r_ys));
                r_z    <= SPAWN_DEPTH;
                r_tint <= w_new_tint;
                r_opx  <= PIX_NONE;
                r_opy  <= PIX_NONE;
                r_draw <= 1'b0;
            end
            default: ;
        endcase
    end

    // projection is resolved in the cycle the second quotient lands
    // (the check state only sequences into the emit path)

    assign m_axis_tvalid = r_mv;
    assign m_axis_tdata  = {4'd0, r_mtint, r_mpy, r_mpx};
    assign m_axis_tlast  = r_mlast;
    assign m_axis_tuser  = r_mdraw;

    // ---------------- checks ----------------
    `SPU_ASSERT_NOW(a_no_accept_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !s_axis_tready, "item accepted during clearing pass")
    `SPU_ASSERT_NXT(a_accept_reads, i_clk, i_rst_n, w_accept, r_state == S_READ, "accepted item did not start a slot read")
    `SPU_ASSERT_NOW(a_draw_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tlast, "draw item not marked last")

endmodule
`default_nettype wire

@@ rtl/spu_ram.sv @@
// ----------------------------------------------------------------------------
// spu_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module spu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ rtl/spu_div.sv @@
// ----------------------------------------------------------------------------
// spu_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module spu_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [spu_pkg::NUM_W-1:0] i_num,
    input  wire logic [spu_pkg::DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic      [spu_pkg::NUM_W-1:0] o_quot
);
    import spu_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   w_trial;
    logic             w_fit;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_q[NUM_W-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_fit};
            r_rem <= w_fit ? DEN_W'(w_trial - {1'b0, r_den}) : w_trial[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the starfield projection update unit: a scoreboard
// keeps its own star store and registers, predicts the erase and draw pixels
// of every accepted slot visit and checks them in order, under random idling
// on both sides, a long result hold-off and several register settings
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [12:0] px;
    logic [12:0] py;
    logic [1:0]  tint;
    bit          draw;
    bit          last;
} pixel_t;

class starfield_scoreboard;
    int unsigned speed, star_count, left, right, bottom, top;
    int          pos_x[4096];
    int          pos_y[4096];
    int          depth[4096];
    logic [1:0]  tint_of[4096];
    int          old_x[4096];
    int          old_y[4096];
    int unsigned slot;
    int unsigned credit;
    pixel_t      pending_pixels[$];
    int          errors;

    function new();
        for (int i = 0; i < 4096; i++) begin
            pos_x[i] = 0; pos_y[i] = 0; depth[i] = -1;
            tint_of[i] = spu_pkg::TINT_WHITE; old_x[i] = -1; old_y[i] = -1;
        end
        slot = 0; credit = 0; errors = 0;
        speed = 64; star_count = 1054;
        left = 0; right = 639; bottom = 0; top = 479;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] val);
        case (idx)
            spu_pkg::CFG_SPEED:         speed = val[11:0];
            spu_pkg::CFG_STAR_COUNT:    star_count = val;
            spu_pkg::CFG_SCREEN_LEFT:   left = val[11:0];
            spu_pkg::CFG_SCREEN_RIGHT:  right = val[11:0];
            spu_pkg::CFG_SCREEN_BOTTOM: bottom = val[11:0];
            spu_pkg::CFG_SCREEN_TOP:    top = val[11:0];
            default: ;
        endcase
    endfunction

    // half-width of the spawn range, floor on the half, truncation on the scale
    function longint spawn_span(int unsigned lo, int unsigned hi);
        longint d;
        d = longint'(hi) - longint'(lo);
        return (((d >>> 1) + 1) * 45000) / 512;
    endfunction

    function void push_pixel(int x, int y, logic [1:0] t, bit draw);
        pixel_t p;
        p.px = x[12:0]; p.py = y[12:0]; p.tint = t; p.draw = draw; p.last = 0;
        pending_pixels.push_back(p);
    endfunction

    function void note_visit(logic [39:0] d);
        int unsigned cnt, s;
        int          n;
        longint      xc, yc, x, y, xs, ys;
        n = 0;
        cnt = star_count;
        if (cnt == 0) cnt = 1;
        if (cnt > 4096) cnt = 4096;
        if (slot >= cnt) slot = 0;
        s = slot;
        if (s == 0) begin
            credit += 3;
            if (credit > 16'hFFFF) credit = 16'hFFFF;
        end
        if (depth[s] > 0) begin
            push_pixel(old_x[s], old_y[s], tint_of[s], 0);
            n++;
            depth[s] -= int'(speed);
            if (depth[s] > 0) begin
                xc = (longint'(left) + longint'(right)) / 2;
                yc = (longint'(bottom) + longint'(top)) / 2;
                x = xc + (512 * longint'(pos_x[s])) / longint'(depth[s]);
                y = yc + (512 * longint'(pos_y[s])) / longint'(depth[s]);
                if (x > right || x < left || y > top || y < bottom) begin
                    depth[s] = -1;
                end else begin
                    old_x[s] = int'(x); old_y[s] = int'(y);
                    push_pixel(old_x[s], old_y[s], tint_of[s], 1);
                    n++;
                end
            end
        end
        if (credit != 0 && depth[s] <= 0) begin
            xs = spawn_span(left, right);
            ys = spawn_span(bottom, top);
            credit--;
            depth[s] = 45512;
            // arithmetic shift gives the floor division by 65536
            pos_x[s] = int'((((2 * xs) * (2 * longint'(d[14:0]))) >>> 16) - xs);
            pos_y[s] = int'((((2 * ys) * (2 * longint'(d[29:15]))) >>> 16) - ys);
            tint_of[s] = (d[35:30] != 0) ? spu_pkg::TINT_WHITE :
                         (d[36] ? spu_pkg::TINT_CYAN : spu_pkg::TINT_RED);
            old_x[s] = -1; old_y[s] = -1;
        end
        slot = s + 1;
        if (slot >= cnt) slot = 0;
        if (n > 0) pending_pixels[$].last = 1;
    endfunction

    function void check_pixel(logic [31:0] data, logic last, logic draw);
        pixel_t e;
        if (pending_pixels.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected pixel: data=%h last=%b draw=%b",
                                       data, last, draw);
            return;
        end
        e = pending_pixels.pop_front();
        if (data[12:0] !== e.px || data[25:13] !== e.py || data[27:26] !== e.tint ||
            data[31:28] !== 4'd0 || last !== e.last || draw !== e.draw) begin
            errors++;
            if (errors <= 10)
                $display("pixel mismatch: exp x=%0d y=%0d tint=%0d draw=%0b last=%0b, got x=%0d y=%0d tint=%0d draw=%0b last=%0b pad=%h",
                         $signed(e.px), $signed(e.py), e.tint, e.draw, e.last,
                         $signed(data[12:0]), $signed(data[25:13]), data[27:26],
                         draw, last, data[31:28]);
        end
    endfunction
endclass

module tb_top;
    localparam int STALL_LIMIT = 20000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_valid = 0;
    logic [2:0]  i_cfg_index = 0;
    logic [12:0] i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic [39:0] s_axis_tdata = 0;
    logic        m_axis_tready = 0;
    wire         o_cfg_ready;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [31:0] m_axis_tdata;
    wire         m_axis_tlast;
    wire         m_axis_tuser;

    starfield_projection_update_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    starfield_scoreboard sb = new();
    bit quiet = 0;        // no idling in the closing part
    bit hold_request = 0; // asks the receiver for one long hold-off
    int stall_cycles = 0;

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // receiver: checks accepted pixels, idles in bursts, honors the hold-off
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            if (hold_request) begin
                hold_request = 0;
                hold = 400;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 9) - 1;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    // watchdog on cycles without any handshake on the input, output or config channel
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (sb.pending_pixels.size() != 0) @(posedge i_clk);
        // a dead slot visit may still be in flight
        repeat (20) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes, the caller drops it
    task automatic write_reg(logic [2:0] idx, logic [12:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
    endtask

    task automatic set_screen(int spd, int cnt, int l, int r, int b, int t);
        wait_drained();
        write_reg(spu_pkg::CFG_SPEED, 13'(spd));
        write_reg(spu_pkg::CFG_STAR_COUNT, 13'(cnt));
        write_reg(spu_pkg::CFG_SCREEN_LEFT, 13'(l));
        write_reg(spu_pkg::CFG_SCREEN_RIGHT, 13'(r));
        write_reg(spu_pkg::CFG_SCREEN_BOTTOM, 13'(b));
        write_reg(spu_pkg::CFG_SCREEN_TOP, 13'(t));
        i_cfg_valid <= 0;
    endtask

    // offers one visit; valid stays high unless an idle burst follows
    task automatic send_visit(logic [14:0] rx, logic [14:0] ry, logic [5:0] gate,
                              logic pick);
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {3'd0, pick, gate, ry, rx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_visit({3'd0, pick, gate, ry, rx});
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic random_visits(int n);
        logic [5:0] gate;
        for (int i = 0; i < n; i++) begin
            // gate forced to zero in one of three draws so cyan and red stars appear often
            gate = ($urandom_range(0, 2) == 0) ? 6'd0 : 6'($urandom);
            send_visit(15'($urandom), 15'($urandom), gate, 1'($urandom));
        end
        s_axis_tvalid <= 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;

        // reset settings: first visits spawn slots 0..2, the rest are dead
        for (int i = 0; i < 6; i++) send_visit(15'd0, 15'd0, 6'd0, i[0]);
        s_axis_tvalid <= 0;

        // directed: three slots, fast, extremes of the random fields and tints
        set_screen(4080, 3, 0, 639, 0, 479);
        send_visit(15'h7FFF, 15'h7FFF, 6'd63, 1'b1);
        send_visit(15'd0, 15'd0, 6'd0, 1'b1);
        send_visit(15'h7FFF, 15'd0, 6'd0, 1'b0);
        send_visit(15'd0, 15'h7FFF, 6'd1, 1'b0);
        send_visit(15'h4000, 15'h4000, 6'd32, 1'b1);
        for (int i = 0; i < 13; i++)
            send_visit(15'h5555 ^ 15'(i), 15'h2AAA ^ 15'(i), 6'(i * 5), i[0]);
        s_axis_tvalid <= 0;

        // slow stars with a long result hold-off so the input side stalls
        set_screen(16, 4, 0, 639, 0, 479);
        random_visits(100);
        hold_request = 1;
        random_visits(150);

        // widest screen, one slot
        set_screen(4080, 1, 0, 4095, 0, 4095);
        random_visits(150);

        // inverted bounds kill every star; zero count acts as one slot
        set_screen(300, 0, 100, 50, 0, 479);
        random_visits(100);

        // largest count: the pointer walks far beyond the slots used so far
        set_screen(64, 8191, 0, 639, 0, 479);
        random_visits(60);

        // narrow window near the top rows
        set_screen(2000, 6, 200, 210, 4000, 4095);
        random_visits(200);

        // single-pixel screen
        set_screen(800, 5, 0, 0, 0, 0);
        random_visits(100);

        set_screen(120, 3, 10, 300, 20, 200);
        random_visits(300);

        // closing part without idling
        set_screen(640, 8, 0, 639, 0, 479);
        quiet = 1;
        random_visits(400);

        wait_drained();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

`default_nettype wire
